// ===== sv/cbm_irq_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with cycle IRQ.
// Used by the top level and by its port checker; no dependencies.
package cbm_irq_pkg;

  // Input item kinds, carried on s_tuser
  typedef enum logic [1:0] {
    KIND_CPU_WRITE = 2'd0,
    KIND_CPU_TICK  = 2'd1,
    KIND_CPU_READ  = 2'd2,
    KIND_PPU_READ  = 2'd3
  } kind_t;

  // Result targets, carried on m_tuser
  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_PRG   = 2'd1,
    TGT_CHR   = 2'd2,
    TGT_CIRAM = 2'd3
  } target_t;

  // Write register groups: address bits [6:4] after the 0x73 decode mask
  typedef enum logic [2:0] {
    GRP_PRG    = 3'd0,
    GRP_CHR_LO = 3'd1,
    GRP_CHR_HI = 3'd2,
    GRP_IRQ_EN = 3'd3,
    GRP_IRQ_AK = 3'd4,
    GRP_NT     = 3'd5
  } wgroup_t;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int ROM_W     = 17;
  localparam int CIRAM_W   = 11;
  localparam int PRG_W     = 4;
  localparam int CHR_W     = 7;
  localparam int CNT_W     = 8;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // Reset value of every PRG bank register
  localparam logic [PRG_W-1:0] PRG_RESET = 4'hF;
  // Bits always forced on in the last PRG bank register
  localparam logic [1:0] PRG_LAST_FORCE = 2'b11;

endpackage

// ===== sv/cartridge_bank_mapper_irq_top.sv =====
// Cartridge bank mapper with a cycle-counting interrupt: bank registers,
// write decode, IRQ counter and address translation. Depends on cbm_irq_pkg.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one item per
//   cycle: a CPU write, a CPU cycle tick, a CPU read to translate or a PPU
//   read to translate (kind on s_tuser). Every item gives exactly one result
//   on the master channel (m_tvalid/m_tready/m_tdata/m_tuser): the target
//   on m_tuser, the PRG/CHR ROM address, the nametable RAM address and the
//   IRQ level after that item on m_tdata.
//   Path: an accepted item is held in the input register, and its result is
//   loaded into the output register once that register is empty or its
//   result is taken; m_tvalid is driven by the output register.
//   Throughput: one item per clock; bank registers and the IRQ counter are
//   read and updated by the same single pass that fills the output register.
//   Stall: while m_tready is low the output register holds its result; one
//   more item is taken if the input register is empty, then s_tready drops.
//   Reset (rst, synchronous): both registers empty, PRG banks all 15, CHR
//   banks and nametable pages zero, IRQ disabled, counter and line cleared.
module cartridge_bank_mapper_irq_top
  import cbm_irq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [15:0] address, [23:16] write_data
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [16:0] rom_address, [27:17] ciram_address, [28] irq_line, [31:29] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  // [1:0] target
  output logic [1:0]           m_tuser
);

  // Input register
  logic              in_valid;
  kind_t             in_kind;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;

  // Mapper state
  logic [PRG_W-1:0] prg_bank [4];
  logic [CHR_W-1:0] chr_bank [8];
  logic [3:0]       nt_page;
  logic             irq_enabled;
  logic [CNT_W-1:0] irq_counter;
  logic             irq_asserted;

  // Output register
  logic               out_valid;
  target_t            out_target;
  logic [ROM_W-1:0]   out_rom;
  logic [CIRAM_W-1:0] out_ciram;
  logic               out_irq;

  // Next values from the single pass
  logic               irq_enabled_next;
  logic [CNT_W-1:0]   irq_counter_next;
  logic               irq_asserted_next;
  target_t            target_next;
  logic [ROM_W-1:0]   rom_next;
  logic [CIRAM_W-1:0] ciram_next;

  logic    out_load;
  logic    in_load;
  logic    wr_en;
  wgroup_t wr_group;
  logic [1:0] wr_lo;

  // Pipeline flow control
  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  // Write decode: address AND 0x73 splits into group [6:4] and index [1:0]
  assign wr_en    = out_load && (in_kind == KIND_CPU_WRITE) && in_addr[15];
  assign wr_group = wgroup_t'(in_addr[6:4]);
  assign wr_lo    = in_addr[1:0];

  // IRQ control and address translation
  always_comb begin
    irq_enabled_next  = irq_enabled;
    irq_counter_next  = irq_counter;
    irq_asserted_next = irq_asserted;
    target_next       = TGT_NONE;
    rom_next          = '0;
    ciram_next        = '0;
    case (in_kind)
      KIND_CPU_WRITE: begin
        if (in_addr[15]) begin
          if (wr_group == GRP_IRQ_EN) begin
            irq_enabled_next = 1'b1;
          end else if (wr_group == GRP_IRQ_AK) begin
            irq_enabled_next  = 1'b0;
            irq_counter_next  = '0;
            irq_asserted_next = 1'b0;
          end
        end
      end
      KIND_CPU_TICK: begin
        if (irq_enabled) begin
          irq_counter_next = irq_counter - CNT_W'(1);
          if (irq_counter == CNT_W'(1)) begin
            irq_asserted_next = 1'b1;
          end
        end
      end
      KIND_CPU_READ: begin
        if (in_addr[15]) begin
          target_next = TGT_PRG;
          rom_next    = {prg_bank[in_addr[14:13]], in_addr[12:0]};
        end
      end
      default: begin
        // PPU: below $2000 (bit 13 clear) is CHR, bit 13 set is nametable space
        if (!in_addr[13]) begin
          target_next = TGT_CHR;
          rom_next    = {chr_bank[in_addr[12:10]], in_addr[9:0]};
        end else begin
          target_next = TGT_CIRAM;
          ciram_next  = {nt_page[in_addr[11:10]], in_addr[9:0]};
        end
      end
    endcase
  end

  // Input register: load when empty or when the pass takes the held item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (in_load) begin
      in_kind <= kind_t'(s_tuser);
      in_addr <= s_tdata[ADDR_W-1:0];
      in_data <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  // Mapper state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        prg_bank[i] <= PRG_RESET;
      end
      for (int i = 0; i < 8; i++) begin
        chr_bank[i] <= '0;
      end
      nt_page      <= '0;
      irq_enabled  <= 1'b0;
      irq_counter  <= '0;
      irq_asserted <= 1'b0;
    end else if (out_load) begin
      irq_enabled  <= irq_enabled_next;
      irq_counter  <= irq_counter_next;
      irq_asserted <= irq_asserted_next;
      if (wr_en) begin
        case (wr_group)
          GRP_PRG: begin
            // last bank keeps bits 2 and 3 forced on
            if (wr_lo == 2'd3) begin
              prg_bank[3] <= {PRG_LAST_FORCE, in_data[1:0]};
            end else begin
              prg_bank[wr_lo] <= in_data[PRG_W-1:0];
            end
          end
          GRP_CHR_LO: chr_bank[{1'b0, wr_lo}] <= in_data[CHR_W-1:0];
          GRP_CHR_HI: chr_bank[{1'b1, wr_lo}] <= in_data[CHR_W-1:0];
          GRP_NT:     nt_page[wr_lo] <= in_data[0];
          default: ;
        endcase
      end
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
    if (out_load) begin
      out_target <= target_next;
      out_rom    <= rom_next;
      out_ciram  <= ciram_next;
      out_irq    <= irq_asserted_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_target;
  assign m_tdata  = {3'b000, out_irq, out_ciram, out_rom};

endmodule

// ===== sv/cbm_irq_checker.sv =====
// Port-level checks for the cartridge bank mapper top level, bound to it.
// Depends on cbm_irq_pkg.
module cbm_irq_checker
  import cbm_irq_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No target: both translated addresses are zero
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == TGT_NONE |-> m_tdata[27:0] == 28'd0)
    else $error("address set for a result with no target");

  // ROM targets leave the nametable address zero, nametable leaves ROM zero
  a_field_split: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == TGT_CIRAM) ? (m_tdata[16:0] == 17'd0)
                                        : (m_tdata[27:17] == 11'd0))
    else $error("unused address field not zero");

  // Padding bits above the IRQ line stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:29] == 3'd0)
    else $error("padding bits of a result not zero");

endmodule

bind cartridge_bank_mapper_irq_top cbm_irq_checker u_cbm_irq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
